>>> sv/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, character codes and the base64 symbol table for the
// line-wrapped base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SYM_W   = 6;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned GROUP_CHARS = 4;
    localparam int unsigned IDX_W   = 3;

    localparam logic [BYTE_W-1:0] CHAR_PAD = 8'd61;   // '='
    localparam logic [BYTE_W-1:0] CHAR_NL  = 8'd10;   // newline
    localparam logic [LINE_W-1:0] MAX_LINE_RESET = 8'd76;
    localparam logic [LINE_W-1:0] GROUP_STEP = 8'd4;

    // One encoded group as it waits for the back end: four characters, first
    // in the lowest byte, plus whether a newline follows and whether it ends
    // the message.
    typedef struct packed {
        logic                              fin;
        logic                              wrap;
        logic [GROUP_CHARS*BYTE_W-1:0]     chars;
    } b64lw_group_t;

    // Standard alphabet A-Z a-z 0-9 + /
    function automatic logic [BYTE_W-1:0] b64_sym(input logic [SYM_W-1:0] v);
        logic [BYTE_W-1:0] ch;
        begin
            if (v < 6'd26)
            begin
                ch = 8'd65 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                ch = 8'd71 + {2'b00, v};
            end
            else if (v < 6'd62)
            begin
                ch = {2'b00, v} - 8'd4;
            end
            else if (v == 6'd62)
            begin
                ch = 8'd43;
            end
            else
            begin
                ch = 8'd47;
            end
            return ch;
        end
    endfunction

endpackage

>>> sv/b64lw_front.sv
// ----------------------------------------------------------------------------
// b64lw_front
// Byte intake: hold pending bytes, build each group's four characters and
// decide the line wrap, then push the group to the queue.
// ----------------------------------------------------------------------------
module b64lw_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         final_byte,
    input  logic [7:0]                   max_line_chars,
    input  logic                         q_full,
    output logic                         q_push,
    output b64lw_pkg::b64lw_group_t      q_group
);
    import b64lw_pkg::*;

    logic [15:0]       held_reg, held_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [LINE_W-1:0] line_reg, line_next;

    logic              accept;
    logic              group_done;
    logic [7:0]        b0, b1, b2;
    logic [LINE_W-1:0] line_inc;
    logic              wrap;
    logic [BYTE_W-1:0] c0, c1, c2, c3;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign group_done = (cnt_reg == 2'd2) || (cnt_reg == 2'd3) || final_byte;
    assign q_push     = accept && group_done;

    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                b0 = data_byte;
                b1 = 8'd0;
                b2 = 8'd0;
            end
            2'd1:
            begin
                b0 = held_reg[15:8];
                b1 = data_byte;
                b2 = 8'd0;
            end
            default:
            begin
                b0 = held_reg[15:8];
                b1 = held_reg[7:0];
                b2 = data_byte;
            end
        endcase
    end

    // Pad slots follow the group size: one byte leaves two pads, two leave one.
    always_comb
    begin
        c0 = b64_sym(b0[7:2]);
        c1 = b64_sym({b0[1:0], b1[7:4]});
        c2 = (cnt_reg == 2'd0) ? CHAR_PAD : b64_sym({b1[3:0], b2[7:6]});
        c3 = ((cnt_reg == 2'd0) || (cnt_reg == 2'd1)) ? CHAR_PAD : b64_sym(b2[5:0]);
    end

    assign line_inc = line_reg + GROUP_STEP;
    assign wrap     = ({1'b0, line_inc} + {1'b0, GROUP_STEP}) > {1'b0, max_line_chars};

    assign q_group.chars = {c3, c2, c1, c0};
    assign q_group.wrap  = wrap;
    assign q_group.fin   = final_byte;

    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        if (accept)
        begin
            if (group_done)
            begin
                held_next = 16'd0;
                cnt_next  = 2'd0;
                line_next = (wrap || final_byte) ? '0 : line_inc;
            end
            else if (cnt_reg == 2'd0)
            begin
                held_next = {data_byte, 8'd0};
                cnt_next  = 2'd1;
            end
            else
            begin
                held_next = {held_reg[15:8], data_byte};
                cnt_next  = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            cnt_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
        end
    end

endmodule

>>> sv/b64lw_queue.sv
// ----------------------------------------------------------------------------
// b64lw_queue
// Two-entry queue of encoded groups between the intake and the serializer.
// ----------------------------------------------------------------------------
module b64lw_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  b64lw_pkg::b64lw_group_t      push_group,
    output logic                         full,
    input  logic                         pop,
    output logic                         empty,
    output b64lw_pkg::b64lw_group_t      head
);
    import b64lw_pkg::*;

    b64lw_group_t slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/b64lw_back.sv
// ----------------------------------------------------------------------------
// b64lw_back
// Serializer: step through the head group one character per word, append
// the newline on a wrap, and hold the word in the output register.
// ----------------------------------------------------------------------------
module b64lw_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  b64lw_pkg::b64lw_group_t      q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_char,
    output logic                         run_last,
    output logic                         message_end
);
    import b64lw_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] char_reg;
    logic              last_reg;
    logic              end_reg;

    logic              load;
    logic              is_last;
    logic [BYTE_W-1:0] sel_char;

    assign load    = !q_empty && (!valid_reg || out_ready);
    assign is_last = q_head.wrap ? (idx_reg == 3'd4) : (idx_reg == 3'd3);
    assign q_pop   = load && is_last;

    always_comb
    begin
        case (idx_reg)
            3'd0:    sel_char = q_head.chars[7:0];
            3'd1:    sel_char = q_head.chars[15:8];
            3'd2:    sel_char = q_head.chars[23:16];
            3'd3:    sel_char = q_head.chars[31:24];
            default: sel_char = CHAR_NL;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= sel_char;
            last_reg <= is_last;
            end_reg  <= is_last && q_head.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign run_last    = last_reg;
    assign message_end = end_reg;

endmodule

>>> sv/base64_encoder_line_wrapped.sv
// ----------------------------------------------------------------------------
// base64_encoder_line_wrapped
// Streaming base64 encoder with line wrapping.
//
// Message bytes enter one word at a time on s_axis, tlast on the last byte
// of a message. Every three bytes (or the shorter final group, zero-filled
// and padded with '=') leave as four characters of the standard alphabet on
// m_axis, one character per word, followed by a newline when the line count
// plus four would exceed max_line_chars (reset 76, written on the cfg port
// while the block is idle; the user is bound to this, the block does not
// enforce it). The output register is paid for once per word, so the
// sustained rate is one output character per cycle while a group is queued
// and m_axis_tready is high. The intake takes one byte per cycle as long as
// the two-entry group queue has room, so bytes that only fill the pending
// group go in back to back while earlier groups are still draining. The
// group a byte closes is queued before its first character is registered.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrapped (
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // final_byte
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tuser,   // run_last
    output logic       m_axis_tlast,   // message_end
    // configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data        // [7:0] max_line_chars
);
    import b64lw_pkg::*;

    logic [LINE_W-1:0] max_line_reg;
    b64lw_group_t      push_group;
    b64lw_group_t      head_group;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    // Always take config words; the limit only matters when a group closes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg <= MAX_LINE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_line_reg <= cfg_data;
        end
    end

    // Front end: collect bytes, encode the group, decide the wrap.
    b64lw_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .data_byte      (s_axis_tdata),
        .final_byte     (s_axis_tlast),
        .max_line_chars (max_line_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_group        (push_group)
    );

    // Decouple intake from character output.
    b64lw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (head_group)
    );

    // Back end: serialize one character per word into the output register.
    b64lw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (head_group),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_char    (m_axis_tdata),
        .run_last    (m_axis_tuser),
        .message_end (m_axis_tlast)
    );

`ifndef SYNTH
    // Never push a group into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("group pushed into full queue");

    // Never pop an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_empty))
        else $error("group popped from empty queue");

    // The end of a message is always the last word of its group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("message end not on the last word of a group");
`endif

endmodule
